// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the step statistics block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock edge, including the reset cycles.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssdr_pkg.sv =====
// Shared types and constants of the step statistics day-rollover block.
// No dependencies; used by every module of the block.
`default_nettype none

package ssdr_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned DAY_W   = 20;
    localparam int unsigned DELTA_W = 16;
    localparam int unsigned CNT_W   = 32;

    // Width of the day difference used by the window test
    localparam int unsigned DIFF_W    = DAY_W + 1;
    // Window reaches back this many days before the stored day
    localparam int unsigned WEEK_BACK = 6;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 184;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_RESET = 2'd2
    } ssdr_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL,
        ST_ADD_TODAY,
        ST_ADD_LIFE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } ssdr_state_t;

    // Control from the sequencer to the history ring
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } ssdr_hist_ctl_t;

endpackage

`default_nettype wire

// ===== src/ssdr_sat_add.sv =====
// Shared 32-bit saturating adder of the step statistics block.
// Depends on ssdr_pkg for the count width.
`default_nettype none

module ssdr_sat_add import ssdr_pkg::*; (
    input  wire logic [CNT_W-1:0] a,
    input  wire logic [CNT_W-1:0] b,
    output logic      [CNT_W-1:0] y
);

    logic [CNT_W:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};
    // Clamp at all ones on carry out
    assign y   = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

endmodule

`default_nettype wire

// ===== src/ssdr_hist.sv =====
// History ring of archived days and step counts, with per-entry valid bits.
// Depends on ssdr_pkg; an entry never written since a clear reads as zero.
`default_nettype none

module ssdr_hist import ssdr_pkg::*; #(
    parameter  int unsigned DEPTH = 8,
    localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ssdr_hist_ctl_t ctl,
    input  wire logic [IW-1:0]  wr_addr,
    input  wire logic [DAY_W-1:0] wr_day,
    input  wire logic [CNT_W-1:0] wr_steps,
    input  wire logic [IW-1:0]  rd_addr,
    output logic [DAY_W-1:0]    rd_day,
    output logic [CNT_W-1:0]    rd_steps
);

    logic [DAY_W-1:0] day_mem   [DEPTH];
    logic [CNT_W-1:0] steps_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DAY_W-1:0] rd_day_reg;
    logic [CNT_W-1:0] rd_steps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            day_mem[wr_addr]   <= wr_day;
            steps_mem[wr_addr] <= wr_steps;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_day_reg   <= valid_reg[rd_addr] ? day_mem[rd_addr]   : '0;
            rd_steps_reg <= valid_reg[rd_addr] ? steps_mem[rd_addr] : '0;
        end
    end

    assign rd_day   = rd_day_reg;
    assign rd_steps = rd_steps_reg;

endmodule

`default_nettype wire

// ===== src/step_stats_day_rollover_top.sv =====
// Top level of the pedometer statistics block: sequencer, state and result register.
// Depends on ssdr_pkg, ssdr_sat_add and ssdr_hist.
//
//  Channel | Dir | Beat                 | Fields (low bit up)
//  s_      | in  | one request per item | tuser: command; tdata: current_day, step_delta
//  m_      | out | one result per item  | tdata: today, week, lifetime, best day,
//          |     |                      |        best week, day_rolled, stored_day
//
// Pace: the block takes one request at a time; the walk over the history ring through
// its single read port, one entry per cycle with each read registered, sets the pace.
// Reset: aresetn is synchronous and active low; it clears the totals, the ring valid
// bits and the result valid flag.
// Stalls: a held result does not block the next request; the sequencer waits in its
// last step only if the previous result is still not taken.
`default_nettype none

module step_stats_day_rollover_top import ssdr_pkg::*; #(
    parameter int unsigned HIST_DAYS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [19:0] current_day, [35:20] step_delta, [39:36] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] today_steps, [63:32] week_steps, [95:64] lifetime_steps,
    // [127:96] best_day_steps, [159:128] best_week_steps, [160] day_rolled,
    // [180:161] stored_day, [183:181] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned IW = (HIST_DAYS > 1) ? $clog2(HIST_DAYS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(HIST_DAYS - 1);

    ssdr_state_t state_reg, state_next;

    // Captured request
    logic [CMD_W-1:0]   cmd_reg,   cmd_next;
    logic [DAY_W-1:0]   cur_reg,   cur_next;
    logic [DELTA_W-1:0] delta_reg, delta_next;

    // Statistics state
    logic [CNT_W-1:0] today_reg, today_next;
    logic [DAY_W-1:0] day_reg,   day_next;
    logic [CNT_W-1:0] life_reg,  life_next;
    logic [CNT_W-1:0] bday_reg,  bday_next;
    logic [CNT_W-1:0] bweek_reg, bweek_next;
    logic [IW-1:0]    head_reg,  head_next;

    // Per-item work registers
    logic             rolled_reg, rolled_next;
    logic             upd_reg,    upd_next;
    logic [CNT_W-1:0] acc_reg,    acc_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] out_today_reg, out_week_reg, out_life_reg;
    logic [CNT_W-1:0] out_bday_reg,  out_bweek_reg;
    logic             out_rolled_reg;
    logic [DAY_W-1:0] out_day_reg;
    logic             out_load;

    // Shared adder and ring
    logic [CNT_W-1:0] add_a, add_b, add_y;
    ssdr_hist_ctl_t   hist_ctl;
    logic [DAY_W-1:0] rd_day;
    logic [CNT_W-1:0] rd_steps;
    logic [DIFF_W-1:0] day_diff;
    logic             in_window;
    logic             rolls;

    ssdr_sat_add u_add (
        .a (add_a),
        .b (add_b),
        .y (add_y)
    );

    ssdr_hist #(
        .DEPTH (HIST_DAYS)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (hist_ctl),
        .wr_addr  (head_reg),
        .wr_day   (day_reg),
        .wr_steps (today_reg),
        .rd_addr  (rd_idx_reg),
        .rd_day   (rd_day),
        .rd_steps (rd_steps)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign rolls    = (cur_reg > day_reg);

    // Archived day counts toward the week if it lies one to six days before the stored day
    assign day_diff  = {1'b0, day_reg} - {1'b0, rd_day};
    assign in_window = (rd_day < day_reg) && (day_diff <= DIFF_W'(WEEK_BACK));

    // Load the result register when it is empty or being drained
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ROLL;
                end
            end
            ST_ROLL: begin
                state_next = (cmd_reg == CMD_ADD) ? ST_ADD_TODAY : ST_WALK;
            end
            ST_ADD_TODAY: begin
                state_next = ST_ADD_LIFE;
            end
            ST_ADD_LIFE: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and control outputs
    always_comb begin
        cmd_next     = cmd_reg;
        cur_next     = cur_reg;
        delta_next   = delta_reg;
        today_next   = today_reg;
        day_next     = day_reg;
        life_next    = life_reg;
        bday_next    = bday_reg;
        bweek_next   = bweek_reg;
        head_next    = head_reg;
        rolled_next  = rolled_reg;
        upd_next     = upd_reg;
        acc_next     = acc_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = 1'b0;
        hist_ctl     = '0;
        add_a        = acc_reg;
        add_b        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                // Capture the request and rewind the ring walk
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    cur_next   = s_tdata[DAY_W-1:0];
                    delta_next = s_tdata[DAY_W +: DELTA_W];
                end
                rd_idx_next = '0;
            end
            ST_ROLL: begin
                if (cmd_reg == CMD_RESET) begin
                    // Clear everything and adopt the request day without a rollover
                    today_next   = '0;
                    day_next     = cur_reg;
                    life_next    = '0;
                    bday_next    = '0;
                    bweek_next   = '0;
                    head_next    = '0;
                    hist_ctl.clr = 1'b1;
                    rolled_next  = 1'b0;
                    upd_next     = 1'b0;
                    acc_next     = '0;
                end else begin
                    rolled_next = rolls;
                    upd_next    = rolls || (cmd_reg == CMD_ADD);
                    acc_next    = rolls ? '0 : today_reg;
                    if (rolls) begin
                        // Archive the ended day unless no day was set yet
                        if (day_reg != '0) begin
                            hist_ctl.wr_en = 1'b1;
                            head_next      = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                        end
                        today_next = '0;
                        day_next   = cur_reg;
                    end
                end
            end
            ST_ADD_TODAY: begin
                add_a      = today_reg;
                add_b      = CNT_W'(delta_reg);
                today_next = add_y;
                acc_next   = add_y;
            end
            ST_ADD_LIFE: begin
                add_a     = life_reg;
                add_b     = CNT_W'(delta_reg);
                life_next = add_y;
                if (today_reg > bday_reg) begin
                    bday_next = today_reg;
                end
            end
            ST_WALK: begin
                hist_ctl.rd_en = 1'b1;
                rd_pend_next   = 1'b1;
                if (rd_idx_reg != LAST_IDX) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                // Refresh the best week only when the records were refreshed
                if (out_load && upd_reg && (acc_reg > bweek_reg)) begin
                    bweek_next = acc_reg;
                end
            end
            default: begin
            end
        endcase

        // Accumulate the ring entry read in the previous cycle
        if (rd_pend_reg) begin
            add_a    = acc_reg;
            add_b    = in_window ? rd_steps : '0;
            acc_next = add_y;
        end
    end

    // Result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            today_reg   <= '0;
            day_reg     <= '0;
            life_reg    <= '0;
            bday_reg    <= '0;
            bweek_reg   <= '0;
            head_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            today_reg   <= today_next;
            day_reg     <= day_next;
            life_reg    <= life_next;
            bday_reg    <= bday_next;
            bweek_reg   <= bweek_next;
            head_reg    <= head_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        delta_reg  <= delta_next;
        rolled_reg <= rolled_next;
        upd_reg    <= upd_next;
        acc_reg    <= acc_next;
        rd_idx_reg <= rd_idx_next;
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_today_reg  <= today_reg;
            out_week_reg   <= acc_reg;
            out_life_reg   <= life_reg;
            out_bday_reg   <= bday_reg;
            out_bweek_reg  <= (upd_reg && (acc_reg > bweek_reg)) ? acc_reg : bweek_reg;
            out_rolled_reg <= rolled_reg;
            out_day_reg    <= day_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_day_reg, out_rolled_reg, out_bweek_reg, out_bday_reg,
                       out_life_reg, out_week_reg, out_today_reg};

endmodule

`default_nettype wire

// ===== src/ssdr_checker.sv =====
// Port-level checker for the step statistics block, bound to the top level.
// Depends on ssdr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ssdr_checker import ssdr_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // One request at a time: busy after an accepted request
    `ASSERT_CLK_RST(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request accepted while busy")

    // No result right after reset
    `ASSERT_CLK(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A rollover always leaves a nonzero stored day
    `ASSERT_CLK_RST(a_rolled_day, aclk, aresetn, m_tvalid && m_tdata[160] |-> m_tdata[180:161] != '0, "rollover to day zero")

    // Today never exceeds lifetime or the week sum
    `ASSERT_CLK_RST(a_today_bound, aclk, aresetn, m_tvalid |-> (m_tdata[31:0] <= m_tdata[95:64]) && (m_tdata[31:0] <= m_tdata[63:32]), "today exceeds lifetime or week")

endmodule

bind step_stats_day_rollover_top ssdr_checker u_ssdr_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for step_stats_day_rollover_top: directed rows, then random
// day walks, checked result by result against an in-bench tally of the pedometer state.
// Depends on ssdr_pkg and the block's RTL; reads no files.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdr_pkg::*;

    localparam int unsigned HIST_DAYS    = 8;
    localparam int unsigned RAND_ITEMS   = 700;
    // last stretch of the random part runs with no idling on either side
    localparam int unsigned QUIET_TAIL   = 120;
    // hold m_tready low this long once, so the block backs up into s_tready
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AFTER   = 200;
    localparam int unsigned DRAIN_CYCLES = 4 * (HIST_DAYS + 6);

    // command value 3 has no enum member; the block treats it as a query
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [DAY_W-1:0] DAY_MAX   = '1;
    localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

    // one result, packed so that it lines up with m_tdata[180:0]
    typedef struct packed {
        logic [DAY_W-1:0] stored_day;
        logic             day_rolled;
        logic [CNT_W-1:0] peak_week;
        logic [CNT_W-1:0] peak_day;
        logic [CNT_W-1:0] lifetime;
        logic [CNT_W-1:0] week;
        logic [CNT_W-1:0] today;
    } tally_t;

    localparam int unsigned TALLY_W = $bits(tally_t);

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [DAY_W-1:0]   day;
        logic [DELTA_W-1:0] delta;
        bit                 typed;
        tally_t             want;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    step_stats_day_rollover_top #(
        .HIST_DAYS(HIST_DAYS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tally of the pedometer state, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] t_today;
    logic [DAY_W-1:0] t_day;
    logic [CNT_W-1:0] t_life;
    logic [CNT_W-1:0] t_best_day;
    logic [CNT_W-1:0] t_best_week;
    logic [DAY_W-1:0] ring_day   [HIST_DAYS];
    logic [CNT_W-1:0] ring_steps [HIST_DAYS];
    int unsigned      ring_head;

    tally_t expected_tallies [$];

    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_errors   = 0;
    int unsigned idle_pct   = 0;
    bit          quiet      = 1'b0;
    bit          hold_done  = 1'b0;

    function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a, b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // today plus every archived day in [stored-6, stored-1]; signed bounds so that
    // small stored days reach below zero
    function automatic logic [CNT_W-1:0] window_sum();
        logic [CNT_W-1:0] acc;
        int lo;
        int hi;
        acc = t_today;
        hi  = int'(t_day) - 1;
        lo  = int'(t_day) - int'(WEEK_BACK);
        for (int i = 0; i < HIST_DAYS; i++) begin
            if (int'(ring_day[i]) >= lo && int'(ring_day[i]) <= hi)
                acc = sat_sum(acc, ring_steps[i]);
        end
        return acc;
    endfunction

    function automatic void refresh_bests();
        logic [CNT_W-1:0] wk;
        if (t_today > t_best_day)
            t_best_day = t_today;
        wk = window_sum();
        if (wk > t_best_week)
            t_best_week = wk;
    endfunction

    function automatic void clear_tally();
        t_today     = '0;
        t_day       = '0;
        t_life      = '0;
        t_best_day  = '0;
        t_best_week = '0;
        ring_head   = 0;
        for (int i = 0; i < HIST_DAYS; i++) begin
            ring_day[i]   = '0;
            ring_steps[i] = '0;
        end
    endfunction

    function automatic tally_t tally_request(input logic [CMD_W-1:0] cmd,
                                             input logic [DAY_W-1:0] day,
                                             input logic [DELTA_W-1:0] delta);
        tally_t r;
        logic   rolled;
        rolled = 1'b0;
        if (cmd == CMD_RESET) begin
            clear_tally();
            t_day = day;
        end else begin
            // forward-only rollover; a stored day of zero archives nothing
            if (day > t_day) begin
                if (t_day != '0) begin
                    ring_day[ring_head]   = t_day;
                    ring_steps[ring_head] = t_today;
                    ring_head = (ring_head + 1) % HIST_DAYS;
                end
                t_today = '0;
                t_day   = day;
                refresh_bests();
                rolled = 1'b1;
            end
            if (cmd == CMD_ADD) begin
                t_today = sat_sum(t_today, CNT_W'(delta));
                t_life  = sat_sum(t_life, CNT_W'(delta));
                refresh_bests();
            end
        end
        r.today      = t_today;
        r.week       = window_sum();
        r.lifetime   = t_life;
        r.peak_day   = t_best_day;
        r.peak_week  = t_best_week;
        r.day_rolled = rolled;
        r.stored_day = t_day;
        return r;
    endfunction

    function automatic tally_t tally(input logic [CNT_W-1:0] today, week, life, bday, bweek,
                                     input logic rolled, input logic [DAY_W-1:0] day);
        tally_t r;
        r.today      = today;
        r.week       = week;
        r.lifetime   = life;
        r.peak_day   = bday;
        r.peak_week  = bweek;
        r.day_rolled = rolled;
        r.stored_day = day;
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic [CMD_W-1:0] cmd,
                                           input logic [DAY_W-1:0] day,
                                           input logic [DELTA_W-1:0] delta,
                                           input bit typed, input tally_t want);
        plan_row_t r;
        r.cmd   = cmd;
        r.day   = day;
        r.delta = delta;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        n_errors++;
        $display("ERROR @%0t result %0d: %s", $time, n_results, msg);
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] seen, want);
        if (seen !== want)
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, seen, want));
    endtask

    always @(posedge aclk) begin : watch_results
        tally_t seen;
        tally_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            seen = m_tdata[TALLY_W-1:0];
            if (expected_tallies.size() == 0) begin
                report_error("result with no request outstanding");
            end else begin
                want = expected_tallies.pop_front();
                check_field("today_steps",     seen.today,     want.today);
                check_field("week_steps",      seen.week,      want.week);
                check_field("lifetime_steps",  seen.lifetime,  want.lifetime);
                check_field("best_day_steps",  seen.peak_day,  want.peak_day);
                check_field("best_week_steps", seen.peak_week, want.peak_week);
                check_field("day_rolled",      CNT_W'(seen.day_rolled), CNT_W'(want.day_rolled));
                check_field("stored_day",      CNT_W'(seen.stored_day), CNT_W'(want.stored_day));
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off that backs
    // the block up until s_tready drops
    // ------------------------------------------------------------------
    initial begin
        forever begin
            if (!hold_done && n_accepted >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken, then advance the tally.
    // A typed row replaces the tally's result with the hand-written one.
    task automatic send_request(input plan_row_t row);
        tally_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {{(S_TDATA_W - DAY_W - DELTA_W){1'b0}}, row.delta, row.day};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = tally_request(row.cmd, row.day, row.delta);
        expected_tallies.push_back(row.typed ? row.want : predicted);
        n_accepted++;
    endtask

    // Drop valid for a random burst when the current idle rate says so.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    function automatic logic [DELTA_W-1:0] pick_delta();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return DELTA_MAX;
        return DELTA_W'($urandom);
    endfunction

    // Mostly well-formed day walks from the current stored day; a few backward
    // days, wild jumps and full resets as noise.
    function automatic plan_row_t random_row();
        plan_row_t   r;
        int unsigned pick;
        int unsigned adv;
        int unsigned next;
        pick    = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.want  = '0;
        r.delta = pick_delta();
        if (pick < 2) begin
            r.cmd = CMD_RESET;
            r.day = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom) :
                                                  DAY_W'($urandom_range(0, 400));
        end else if (pick < 6) begin
            r.cmd = $urandom_range(0, 1) ? CMD_ADD : CMD_QUERY;
            r.day = (t_day == '0) ? '0 : DAY_W'($urandom_range(0, int'(t_day) - 1));
        end else if (pick < 8) begin
            r.cmd = ($urandom_range(0, 2) == 0) ? CMD_QUERY : CMD_ADD;
            r.day = DAY_W'($urandom);
        end else begin
            adv = $urandom_range(0, 99);
            if (adv < 55)
                adv = 0;
            else if (adv < 80)
                adv = 1;
            else if (adv < 92)
                adv = $urandom_range(2, 3);
            else
                adv = $urandom_range(4, 9);
            next  = int'(t_day) + adv;
            r.day = (next > int'(DAY_MAX)) ? DAY_MAX : DAY_W'(next);
            pick  = $urandom_range(0, 99);
            r.cmd = (pick < 75) ? CMD_ADD : (pick < 93) ? CMD_QUERY : CMD_SPARE;
        end
        return r;
    endfunction

    initial begin : stimulus
        plan_row_t plan [$];
        tally_t    no_tally;
        no_tally = '0;
        clear_tally();

        // Hand-written rows carry their result where it reads off directly:
        // empty state, day extremes, the first rollover from no day, resets.
        plan = '{
            plan_row(CMD_QUERY, 20'd0, 16'd0, 1'b1, tally(0, 0, 0, 0, 0, 1'b0, 20'd0)),
            plan_row(CMD_ADD, 20'd0, DELTA_MAX, 1'b1,
                     tally(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b0, 20'd0)),
            // rollover from no day archives nothing
            plan_row(CMD_QUERY, 20'd1, DELTA_MAX, 1'b1,
                     tally(0, 0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b1, 20'd1)),
            plan_row(CMD_RESET, DAY_MAX, DELTA_MAX, 1'b1, tally(0, 0, 0, 0, 0, 1'b0, DAY_MAX)),
            plan_row(CMD_ADD, DAY_MAX, 16'd0, 1'b0, no_tally),
            plan_row(CMD_RESET, 20'd100, 16'd0, 1'b1, tally(0, 0, 0, 0, 0, 1'b0, 20'd100)),
            // consecutive days, more than the ring holds, so the head wraps
            plan_row(CMD_ADD, 20'd100, 16'd1000, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd101, 16'd2000, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd102, 16'd3000, 1'b0, no_tally),
            plan_row(CMD_QUERY, 20'd103, 16'd0, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd104, DELTA_MAX, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd105, 16'd12345, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd106, 16'd1, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd107, 16'd500, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd108, 16'h8000, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd110, 16'd77, 1'b0, no_tally),
            // backward day keeps adding into the stored day
            plan_row(CMD_ADD, 20'd50, 16'd7, 1'b0, no_tally),
            plan_row(CMD_SPARE, 20'd112, DELTA_MAX, 1'b0, no_tally),
            plan_row(CMD_QUERY, 20'd112, 16'd0, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'd113, 16'hAAAA, 1'b0, no_tally),
            plan_row(CMD_ADD, 20'h80000, 16'h5555, 1'b0, no_tally),
            plan_row(CMD_QUERY, DAY_MAX, 16'd0, 1'b0, no_tally),
            plan_row(CMD_RESET, 20'd0, DELTA_MAX, 1'b1, tally(0, 0, 0, 0, 0, 1'b0, 20'd0)),
            plan_row(CMD_ADD, 20'd0, 16'd0, 1'b1, tally(0, 0, 0, 0, 0, 1'b0, 20'd0))
        };

        // hold reset, release it, and start offering at once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        idle_pct = 20;
        foreach (plan[i]) begin
            send_request(plan[i]);
            maybe_idle();
        end

        for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
            // change the idle rate now and then, with whole stretches at zero
            if (n % 50 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (n >= RAND_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_request(random_row());
            maybe_idle();
        end
        s_tvalid <= 1'b0;

        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TIMEOUT: %0d results still outstanding", expected_tallies.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ssdr_pkg.sv
src/ssdr_sat_add.sv
src/ssdr_hist.sv
src/step_stats_day_rollover_top.sv
src/ssdr_checker.sv
tb/tb.sv
